[rtl/core/obb_pkg.sv]
// Shared types, constants and the mode table of the orthonormal basis builder.
`default_nettype none
package obb_pkg;

  // Output component width and mode code width.
  localparam int OUT_W = 16;
  localparam int FUNC_W = 4;

  // An aligned magnitude has its leading one at bit ALN_W-1.
  localparam int ALN_W = 30;
  // Sum of three squared aligned magnitudes, and its integer square root.
  localparam int SQ_W = 62;
  localparam int ROOT_W = 31;
  // Magnitude width of the vector that enters the second normalization.
  localparam int CROSS_MAG_W = 62;

  // Mode codes.
  localparam logic [FUNC_W-1:0] FUNC_U  = 4'd0;
  localparam logic [FUNC_W-1:0] FUNC_V  = 4'd1;
  localparam logic [FUNC_W-1:0] FUNC_W_ = 4'd2;
  localparam logic [FUNC_W-1:0] FUNC_UV = 4'd3;
  localparam logic [FUNC_W-1:0] FUNC_VU = 4'd4;
  localparam logic [FUNC_W-1:0] FUNC_UW = 4'd5;
  localparam logic [FUNC_W-1:0] FUNC_WU = 4'd6;
  localparam logic [FUNC_W-1:0] FUNC_VW = 4'd7;
  localparam logic [FUNC_W-1:0] FUNC_WV = 4'd8;

  // Axis slots.
  typedef logic [1:0] slot_t;
  localparam slot_t SLOT_U = 2'd0;
  localparam slot_t SLOT_V = 2'd1;
  localparam slot_t SLOT_W = 2'd2;

  // Decoded mode: which slot is pinned, which gets the helper, which is the
  // third axis, and the operands of the final cross product.
  typedef struct packed {
    logic  ok;
    logic  plane;
    slot_t pin;
    slot_t helper;
    logic  swap;
    slot_t third;
    slot_t ca;
    slot_t cb;
  } mode_t;

  function automatic mode_t mode_lookup(input logic [FUNC_W-1:0] func);
    mode_t m;
    m = '0;
    unique case (func)
      FUNC_U:  m = '{1'b1, 1'b0, SLOT_U, SLOT_V, 1'b0, SLOT_W, SLOT_U, SLOT_V};
      FUNC_V:  m = '{1'b1, 1'b0, SLOT_V, SLOT_U, 1'b0, SLOT_W, SLOT_U, SLOT_V};
      FUNC_W_: m = '{1'b1, 1'b0, SLOT_W, SLOT_U, 1'b0, SLOT_V, SLOT_W, SLOT_U};
      FUNC_UV: m = '{1'b1, 1'b1, SLOT_U, SLOT_W, 1'b0, SLOT_V, SLOT_W, SLOT_U};
      FUNC_VU: m = '{1'b1, 1'b1, SLOT_V, SLOT_W, 1'b1, SLOT_U, SLOT_V, SLOT_W};
      FUNC_UW: m = '{1'b1, 1'b1, SLOT_U, SLOT_V, 1'b1, SLOT_W, SLOT_U, SLOT_V};
      FUNC_WU: m = '{1'b1, 1'b1, SLOT_W, SLOT_V, 1'b0, SLOT_U, SLOT_V, SLOT_W};
      FUNC_VW: m = '{1'b1, 1'b1, SLOT_V, SLOT_U, 1'b0, SLOT_W, SLOT_U, SLOT_V};
      FUNC_WV: m = '{1'b1, 1'b1, SLOT_W, SLOT_U, 1'b1, SLOT_V, SLOT_W, SLOT_U};
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

[rtl/core/obb_if.sv]
// Valid/ready channel interfaces for the direction input and the basis output.
`default_nettype none
interface obb_in_if #(
  parameter int IN_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic [obb_pkg::FUNC_W-1:0]    func;
  logic signed [IN_WIDTH-1:0]    first_x;
  logic signed [IN_WIDTH-1:0]    first_y;
  logic signed [IN_WIDTH-1:0]    first_z;
  logic signed [IN_WIDTH-1:0]    second_x;
  logic signed [IN_WIDTH-1:0]    second_y;
  logic signed [IN_WIDTH-1:0]    second_z;

  modport source (output valid, func, first_x, first_y, first_z,
                  second_x, second_y, second_z, input ready);
  modport sink (input valid, func, first_x, first_y, first_z,
                second_x, second_y, second_z, output ready);
endinterface

interface obb_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [obb_pkg::OUT_W-1:0] u_x;
  logic signed [obb_pkg::OUT_W-1:0] u_y;
  logic signed [obb_pkg::OUT_W-1:0] u_z;
  logic signed [obb_pkg::OUT_W-1:0] v_x;
  logic signed [obb_pkg::OUT_W-1:0] v_y;
  logic signed [obb_pkg::OUT_W-1:0] v_z;
  logic signed [obb_pkg::OUT_W-1:0] w_x;
  logic signed [obb_pkg::OUT_W-1:0] w_y;
  logic signed [obb_pkg::OUT_W-1:0] w_z;
  logic                            degenerate;

  modport source (output valid, u_x, u_y, u_z, v_x, v_y, v_z, w_x, w_y, w_z,
                  degenerate, input ready);
  modport sink (input valid, u_x, u_y, u_z, v_x, v_y, v_z, w_x, w_y, w_z,
                degenerate, output ready);
endinterface
`default_nettype wire

[rtl/core/obb_align.sv]
// Two-stage power-of-two alignment of 3-D magnitude vectors.
`default_nettype none
module obb_align #(
  parameter int W  = 16,
  parameter int NV = 1,
  parameter int TW = 1
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          ce,
  input  logic                                          in_valid,
  input  logic [NV-1:0][2:0][W-1:0]                     mag_in,
  input  logic [NV-1:0][2:0]                            neg_in,
  input  logic [TW-1:0]                                 tag_in,
  output logic                                          out_valid,
  output logic [NV-1:0][2:0][obb_pkg::ALN_W-1:0]        aln_out,
  output logic [NV-1:0][2:0]                            neg_out,
  output logic [NV-1:0]                                 zero_out,
  output logic [TW-1:0]                                 tag_out
);
  import obb_pkg::*;

  localparam int PW = $clog2(W);
  localparam int SW = W + ALN_W - 1;

  logic                      v1;
  logic [NV-1:0][2:0][W-1:0] mag1;
  logic [NV-1:0][2:0]        neg1;
  logic [NV-1:0][PW-1:0]     pos1;
  logic [NV-1:0]             zero1;
  logic [TW-1:0]             tag1;

  logic [NV-1:0][W-1:0]            orw;
  logic [NV-1:0][PW-1:0]           pos_next;
  logic [NV-1:0][2:0][ALN_W-1:0]   aln_next;

  // Leading-one position of the largest component, found from the OR of all three.
  always_comb begin
    for (int n = 0; n < NV; n++) begin
      orw[n] = mag_in[n][0] | mag_in[n][1] | mag_in[n][2];
      pos_next[n] = '0;
      for (int b = 0; b < W; b++) begin
        if (orw[n][b]) pos_next[n] = PW'(b);
      end
    end
  end

  // Shift so that the leading one lands at the top aligned bit; right shifts truncate.
  always_comb begin
    for (int n = 0; n < NV; n++) begin
      for (int i = 0; i < 3; i++) begin
        aln_next[n][i] = ALN_W'((SW'(mag1[n][i]) << (ALN_W - 1)) >> pos1[n]);
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  // Data stages.
  always_ff @(posedge clk) begin
    if (ce) begin
      mag1 <= mag_in;
      neg1 <= neg_in;
      pos1 <= pos_next;
      tag1 <= tag_in;
      for (int n = 0; n < NV; n++) zero1[n] <= (orw[n] == '0);
      aln_out <= aln_next;
      neg_out <= neg1;
      zero_out <= zero1;
      tag_out <= tag1;
    end
  end

endmodule
`default_nettype wire

[rtl/core/obb_norm.sv]
// Pipelined normalization of an aligned vector: squares, sum, square root, divide.
`default_nettype none
module obb_norm #(
  parameter int FRAC_BITS = 14,
  parameter int TW = 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 ce,
  input  logic                                 in_valid,
  input  logic [2:0][obb_pkg::ALN_W-1:0]       mag_in,
  input  logic [2:0]                           neg_in,
  input  logic                                 zero_in,
  input  logic [TW-1:0]                        tag_in,
  output logic                                 out_valid,
  output logic [2:0][FRAC_BITS+1:0]            q_out,
  output logic                                 zero_out,
  output logic [TW-1:0]                        tag_out
);
  import obb_pkg::*;

  localparam int SQ_STEPS = SQ_W / 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int QV = FRAC_BITS + 2;
  localparam int NW = ALN_W + FRAC_BITS + 1;
  localparam int RW = ROOT_W + 2;
  localparam int PREP_AT = 2 + SQ_STEPS;
  localparam int LAT = PREP_AT + 1 + QW;
  localparam int SIDE_W = TW + 4 + 3 * ALN_W;

  logic [LAT-1:0]                vld;
  logic [SIDE_W-1:0]             side [LAT];
  logic [2:0][2*ALN_W-1:0]       sq;
  logic [SQ_W-1:0]               s_sum;
  logic [RW-1:0]                 rt_rem  [SQ_STEPS];
  logic [ROOT_W-1:0]             rt_root [SQ_STEPS];
  logic [SQ_W-1:0]               rt_bits [SQ_STEPS];
  logic [ROOT_W-1:0]             dv_len  [QW+1];
  logic [2:0][ROOT_W-1:0]        dv_rem  [QW+1];
  logic [2:0][QW-1:0]            dv_low  [QW+1];
  logic [2:0][ALN_W-1:0]         prep_mag;
  logic [2:0][NW-1:0]            num;
  logic [SIDE_W-1:0]             side_o;

  // Valid bits and the side data travel together with each beat.
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (ce) vld <= {vld[LAT-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side[0] <= {tag_in, zero_in, neg_in, mag_in};
      for (int k = 1; k < LAT; k++) side[k] <= side[k-1];
    end
  end

  // Squares, then their sum.
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) sq[i] <= mag_in[i] * mag_in[i];
      s_sum <= SQ_W'(sq[0]) + SQ_W'(sq[1]) + SQ_W'(sq[2]);
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [RW-1:0]     rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SQ_W-1:0]   bits_in;
    logic [RW+1:0]     cur;
    logic [RW+1:0]     trial;
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign root_in = '0;
      assign bits_in = s_sum;
    end else begin : g_next
      assign rem_in = rt_rem[k-1];
      assign root_in = rt_root[k-1];
      assign bits_in = rt_bits[k-1];
    end
    assign cur = {rem_in, bits_in[SQ_W-1 -: 2]};
    assign trial = (RW + 2)'({root_in, 2'b01});
    always_ff @(posedge clk) begin
      if (ce) begin
        if (cur >= trial) begin
          rt_rem[k] <= RW'(cur - trial);
          rt_root[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rt_rem[k] <= RW'(cur);
          rt_root[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
        rt_bits[k] <= bits_in << 2;
      end
    end
  end

  // Numerator with rounding term: mag * 2^FRAC_BITS + floor(L / 2).
  assign prep_mag = side[PREP_AT-1][3*ALN_W-1:0];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, prep_mag[i], FRAC_BITS'(0)}
             + NW'(rt_root[SQ_STEPS-1] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dv_len[0] <= rt_root[SQ_STEPS-1];
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= ROOT_W'(num[i][NW-1:QW]);
        dv_low[0][i] <= num[i][QW-1:0];
      end
    end
  end

  // Restoring division, one quotient bit per stage for all three lanes.
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [2:0][ROOT_W:0] cur;
    logic [2:0]           ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        cur[i] = {dv_rem[j][i], dv_low[j][i][QW-1]};
        ge[i] = cur[i] >= {1'b0, dv_len[j]};
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        dv_len[j+1] <= dv_len[j];
        for (int i = 0; i < 3; i++) begin
          dv_rem[j+1][i] <= ge[i] ? ROOT_W'(cur[i] - {1'b0, dv_len[j]})
                                  : ROOT_W'(cur[i]);
          dv_low[j+1][i] <= {dv_low[j][i][QW-2:0], ge[i]};
        end
      end
    end
  end

  // Apply signs; a zero vector gives a zero result.
  assign side_o = side[LAT-1];
  assign out_valid = vld[LAT-1];
  assign zero_out = side_o[3*ALN_W+3];
  assign tag_out = side_o[SIDE_W-1 -: TW];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (zero_out) q_out[i] = '0;
      else if (side_o[3*ALN_W+i]) q_out[i] = -QV'(dv_low[QW][i]);
      else q_out[i] = QV'(dv_low[QW][i]);
    end
  end

endmodule
`default_nettype wire

[rtl/core/obb_cross.sv]
// Two-stage exact cross product of two signed 3-D vectors.
`default_nettype none
module obb_cross #(
  parameter int AW = 16,
  parameter int TW = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ce,
  input  logic                   in_valid,
  input  logic [2:0][AW-1:0]     a,
  input  logic [2:0][AW-1:0]     b,
  input  logic [TW-1:0]          tag_in,
  output logic                   out_valid,
  output logic [2:0][2*AW:0]     r,
  output logic [TW-1:0]          tag_out
);

  logic                        v1;
  logic signed [2*AW-1:0]      pr [6];
  logic [TW-1:0]               tag1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  // Six products, then three differences.
  always_ff @(posedge clk) begin
    if (ce) begin
      pr[0] <= $signed(a[1]) * $signed(b[2]);
      pr[1] <= $signed(a[2]) * $signed(b[1]);
      pr[2] <= $signed(a[2]) * $signed(b[0]);
      pr[3] <= $signed(a[0]) * $signed(b[2]);
      pr[4] <= $signed(a[0]) * $signed(b[1]);
      pr[5] <= $signed(a[1]) * $signed(b[0]);
      tag1 <= tag_in;
      r[0] <= (2*AW+1)'(pr[0]) - (2*AW+1)'(pr[1]);
      r[1] <= (2*AW+1)'(pr[2]) - (2*AW+1)'(pr[3]);
      r[2] <= (2*AW+1)'(pr[4]) - (2*AW+1)'(pr[5]);
      tag_out <= tag1;
    end
  end

endmodule
`default_nettype wire

[rtl/core/orthonormal_basis_builder_unit.sv]
// Top level of the orthonormal basis builder: a deep pipeline, one basis per cycle.
//
//   Channel | Role   | Beat contents
//   --------+--------+----------------------------------------------------
//   dirs    | sink   | func, first_x/y/z, second_x/y/z
//   basis   | source | u_x..w_z in Q2.14 (FRAC_BITS fraction bits), degenerate
//
// One beat enters and one leaves per cycle while basis is not stalled. The pipeline
// holds two square-root chains of 31 stages and two divide chains of FRAC_BITS + 1
// stages. Reset clears only the valid bits.
// A stall on basis freezes the whole pipeline; dirs.ready is low for that cycle.
`default_nettype none
module orthonormal_basis_builder_unit #(
  parameter int IN_WIDTH = 16,
  parameter int FRAC_BITS = 14
) (
  input  logic      clk,
  input  logic      rst,
  obb_in_if.sink    dirs,
  obb_out_if.source basis
);
  import obb_pkg::*;

  localparam int MW  = $bits(mode_t);
  localparam int AW1 = ALN_W + 1;
  localparam int C1W = 2 * AW1 + 1;
  localparam int QV  = FRAC_BITS + 2;
  localparam int CR  = 2 * QV + 1;
  localparam int SSW = 2 * QV + 1;
  localparam logic [63:0] HELP_T = ((64'd1 << (2 * FRAC_BITS)) + 64'd9999) / 64'd10000;

  logic ce;

  // Global pipeline enable: advance unless a finished beat waits on basis.
  assign ce = !basis.valid || basis.ready;
  assign dirs.ready = ce;

  // Sign and magnitude of both input vectors.
  logic [1:0][2:0][IN_WIDTH-1:0] in_raw;
  logic [1:0][2:0][IN_WIDTH-1:0] in_mag;
  logic [1:0][2:0]               in_neg;
  mode_t                         in_mode;

  assign in_raw[0] = {dirs.first_z, dirs.first_y, dirs.first_x};
  assign in_raw[1] = {dirs.second_z, dirs.second_y, dirs.second_x};
  assign in_mode = mode_lookup(dirs.func);

  always_comb begin
    for (int n = 0; n < 2; n++) begin
      for (int i = 0; i < 3; i++) begin
        in_neg[n][i] = in_raw[n][i][IN_WIDTH-1];
        in_mag[n][i] = in_neg[n][i] ? -in_raw[n][i] : in_raw[n][i];
      end
    end
  end

  // Align both input vectors.
  logic                        a1_v;
  logic [1:0][2:0][ALN_W-1:0]  a1_mag;
  logic [1:0][2:0]             a1_neg;
  logic [1:0]                  a1_zero;
  mode_t                       a1_mode;

  obb_align #(.W(IN_WIDTH), .NV(2), .TW(MW)) u_align_in (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(dirs.valid),
    .mag_in(in_mag), .neg_in(in_neg), .tag_in(in_mode),
    .out_valid(a1_v), .aln_out(a1_mag), .neg_out(a1_neg),
    .zero_out(a1_zero), .tag_out(a1_mode)
  );

  // Plane modes: cross the aligned inputs, in the order the mode asks for.
  logic [1:0][2:0][AW1-1:0] a1_s;
  logic [2:0][AW1-1:0]      cx_a;
  logic [2:0][AW1-1:0]      cx_b;

  always_comb begin
    for (int n = 0; n < 2; n++) begin
      for (int i = 0; i < 3; i++) begin
        a1_s[n][i] = a1_neg[n][i] ? -AW1'(a1_mag[n][i]) : AW1'(a1_mag[n][i]);
      end
    end
    cx_a = a1_mode.swap ? a1_s[1] : a1_s[0];
    cx_b = a1_mode.swap ? a1_s[0] : a1_s[1];
  end

  localparam int C1TW = MW + 4 + 3 * ALN_W;
  logic                    c1_v;
  logic [2:0][C1W-1:0]     c1_r;
  logic [C1TW-1:0]         c1_tag;
  mode_t                   c1_mode;
  logic                    c1_zero;
  logic [2:0]              c1_neg;
  logic [2:0][ALN_W-1:0]   c1_mag;

  obb_cross #(.AW(AW1), .TW(C1TW)) u_cross_in (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(a1_v), .a(cx_a), .b(cx_b),
    .tag_in({a1_mode, a1_zero[0], a1_neg[0], a1_mag[0]}),
    .out_valid(c1_v), .r(c1_r), .tag_out(c1_tag)
  );
  assign {c1_mode, c1_zero, c1_neg, c1_mag} = c1_tag;

  // Normalize the first vector into the pinned axis.
  localparam int N1TW = MW + 3 * C1W;
  logic                    n1_v;
  logic [2:0][QV-1:0]      n1_p;
  logic                    n1_zero;
  logic [N1TW-1:0]         n1_tag;
  mode_t                   n1_mode;
  logic [2:0][C1W-1:0]     n1_c;

  obb_norm #(.FRAC_BITS(FRAC_BITS), .TW(N1TW)) u_norm_pin (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(c1_v),
    .mag_in(c1_mag), .neg_in(c1_neg), .zero_in(c1_zero), .tag_in({c1_mode, c1_r}),
    .out_valid(n1_v), .q_out(n1_p), .zero_out(n1_zero), .tag_out(n1_tag)
  );
  assign {n1_mode, n1_c} = n1_tag;

  // Helper stage one: squares of the pinned axis y and z components.
  logic                    h1_v;
  logic [2:0][QV-1:0]      h1_p;
  logic [2*QV-1:0]         h1_sq1;
  logic [2*QV-1:0]         h1_sq2;
  mode_t                   h1_mode;
  logic                    h1_zero;
  logic [2:0][C1W-1:0]     h1_c;

  // Helper stage two: pick the x-axis or y-axis helper, or the plane cross.
  logic                          h2_v;
  logic [2:0][CROSS_MAG_W-1:0]   h2_mag;
  logic [2:0]                    h2_neg;
  mode_t                         h2_mode;
  logic                          h2_zero;
  logic [2:0][QV-1:0]            h2_p;

  logic [SSW-1:0]                h_s;
  logic                          h_small;
  logic [2:0][QV-1:0]            h_vec;
  logic [2:0][QV-1:0]            h_abs;
  logic [2:0][C1W-1:0]           c_abs;
  logic [2:0][CROSS_MAG_W-1:0]   h2_mag_next;
  logic [2:0]                    h2_neg_next;

  always_comb begin
    h_s = SSW'(h1_sq1) + SSW'(h1_sq2);
    h_small = h_s < SSW'(HELP_T);
    if (h_small) begin
      h_vec[0] = -h1_p[2];
      h_vec[1] = '0;
      h_vec[2] = h1_p[0];
    end else begin
      h_vec[0] = '0;
      h_vec[1] = h1_p[2];
      h_vec[2] = -h1_p[1];
    end
    for (int i = 0; i < 3; i++) begin
      h_abs[i] = h_vec[i][QV-1] ? -h_vec[i] : h_vec[i];
      c_abs[i] = h1_c[i][C1W-1] ? -h1_c[i] : h1_c[i];
      if (h1_mode.plane) begin
        h2_neg_next[i] = h1_c[i][C1W-1];
        h2_mag_next[i] = CROSS_MAG_W'(c_abs[i]);
      end else begin
        h2_neg_next[i] = h_vec[i][QV-1];
        h2_mag_next[i] = CROSS_MAG_W'(h_abs[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h1_v <= 1'b0;
      h2_v <= 1'b0;
    end else if (ce) begin
      h1_v <= n1_v;
      h2_v <= h1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      h1_p <= n1_p;
      h1_sq1 <= (2*QV)'($signed(n1_p[1]) * $signed(n1_p[1]));
      h1_sq2 <= (2*QV)'($signed(n1_p[2]) * $signed(n1_p[2]));
      h1_mode <= n1_mode;
      h1_zero <= n1_zero;
      h1_c <= n1_c;
      h2_mag <= h2_mag_next;
      h2_neg <= h2_neg_next;
      h2_mode <= h1_mode;
      h2_zero <= h1_zero;
      h2_p <= h1_p;
    end
  end

  // Align and normalize the helper axis.
  localparam int HTW = MW + 1 + 3 * QV;
  logic                    a2_v;
  logic [0:0][2:0][ALN_W-1:0] a2_mag;
  logic [0:0][2:0]         a2_neg;
  logic [0:0]              a2_zero;
  logic [HTW-1:0]          a2_tag;

  obb_align #(.W(CROSS_MAG_W), .NV(1), .TW(HTW)) u_align_help (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(h2_v),
    .mag_in(h2_mag), .neg_in(h2_neg), .tag_in({h2_mode, h2_zero, h2_p}),
    .out_valid(a2_v), .aln_out(a2_mag), .neg_out(a2_neg),
    .zero_out(a2_zero), .tag_out(a2_tag)
  );

  logic                    n2_v;
  logic [2:0][QV-1:0]      n2_h;
  logic                    n2_zero;
  logic [HTW-1:0]          n2_tag;
  mode_t                   n2_mode;
  logic                    n2_zero1;
  logic [2:0][QV-1:0]      n2_p;

  obb_norm #(.FRAC_BITS(FRAC_BITS), .TW(HTW)) u_norm_help (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(a2_v),
    .mag_in(a2_mag[0]), .neg_in(a2_neg[0]), .zero_in(a2_zero[0]), .tag_in(a2_tag),
    .out_valid(n2_v), .q_out(n2_h), .zero_out(n2_zero), .tag_out(n2_tag)
  );
  assign {n2_mode, n2_zero1, n2_p} = n2_tag;

  // Third axis: cross of the two unit axes in the order the mode gives.
  logic                    n2_deg;
  logic [2:0][QV-1:0]      x_a;
  logic [2:0][QV-1:0]      x_b;

  assign n2_deg = !n2_mode.ok || n2_zero1 || (n2_mode.plane && n2_zero);
  assign x_a = (n2_mode.ca == n2_mode.pin) ? n2_p : n2_h;
  assign x_b = (n2_mode.cb == n2_mode.pin) ? n2_p : n2_h;

  localparam int C2TW = MW + 1 + 6 * QV;
  logic                    c2_v;
  logic [2:0][CR-1:0]      c2_r;
  logic [C2TW-1:0]         c2_tag;
  mode_t                   c2_mode;
  logic                    c2_deg;
  logic [2:0][QV-1:0]      c2_p;
  logic [2:0][QV-1:0]      c2_h;

  obb_cross #(.AW(QV), .TW(C2TW)) u_cross_out (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(n2_v), .a(x_a), .b(x_b),
    .tag_in({n2_mode, n2_deg, n2_p, n2_h}),
    .out_valid(c2_v), .r(c2_r), .tag_out(c2_tag)
  );
  assign {c2_mode, c2_deg, c2_p, c2_h} = c2_tag;

  // Round half away from zero and saturate to one.
  function automatic logic [QV-1:0] qround(input logic [CR-1:0] c);
    logic          neg;
    logic [CR-1:0] mg;
    logic [CR-1:0] rr;
    neg = c[CR-1];
    mg = neg ? -c : c;
    rr = (mg + (CR'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (rr > (CR'(1) << FRAC_BITS)) rr = CR'(1) << FRAC_BITS;
    return neg ? -QV'(rr) : QV'(rr);
  endfunction

  // Place the three axes in their slots.
  logic [2:0][QV-1:0]      third;
  logic [2:0][2:0][QV-1:0] ax;

  always_comb begin
    for (int i = 0; i < 3; i++) third[i] = qround(c2_r[i]);
    for (int s = 0; s < 3; s++) begin
      if (c2_deg) ax[s] = '0;
      else if (c2_mode.pin == slot_t'(s)) ax[s] = c2_p;
      else if (c2_mode.helper == slot_t'(s)) ax[s] = c2_h;
      else ax[s] = third;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) basis.valid <= 1'b0;
    else if (ce) basis.valid <= c2_v;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      basis.u_x <= OUT_W'($signed(ax[SLOT_U][0]));
      basis.u_y <= OUT_W'($signed(ax[SLOT_U][1]));
      basis.u_z <= OUT_W'($signed(ax[SLOT_U][2]));
      basis.v_x <= OUT_W'($signed(ax[SLOT_V][0]));
      basis.v_y <= OUT_W'($signed(ax[SLOT_V][1]));
      basis.v_z <= OUT_W'($signed(ax[SLOT_V][2]));
      basis.w_x <= OUT_W'($signed(ax[SLOT_W][0]));
      basis.w_y <= OUT_W'($signed(ax[SLOT_W][1]));
      basis.w_z <= OUT_W'($signed(ax[SLOT_W][2]));
      basis.degenerate <= c2_deg;
    end
  end

endmodule
`default_nettype wire
